FILE: sv/pid_pkg.sv
// Shared types, register indexes, widths and saturation helpers for the PID core.
// Has no dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none
package pid_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned NUM_W     = 2 * DATA_W - 1;
  localparam int unsigned DEN_W     = DATA_W + 1;
  localparam int unsigned DIV_CNT_W = $clog2(NUM_W + 1);

  localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

  localparam logic signed [31:0] RST_PROP_GAIN       = 32'sd65536;
  localparam logic signed [31:0] RST_INTEGRAL_COEF   = 32'sd65536;
  localparam logic signed [31:0] RST_DERIV_TIME      = 32'sd65536;
  localparam logic signed [31:0] RST_DERIV_FILTER    = 32'sd65536;
  localparam logic signed [31:0] RST_SETPOINT_WEIGHT = 32'sd65536;
  localparam logic signed [31:0] RST_OUT_MIN         = 32'sd0;
  localparam logic signed [31:0] RST_OUT_MAX         = 32'sd6553600;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN       = 3'd0,
    REG_INTEGRAL_COEF   = 3'd1,
    REG_DERIV_TIME      = 3'd2,
    REG_DERIV_FILTER    = 3'd3,
    REG_SETPOINT_WEIGHT = 3'd4,
    REG_OUT_MIN         = 3'd5,
    REG_OUT_MAX         = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BW,
    ST_E,
    ST_KTI,
    ST_P,
    ST_IE,
    ST_KN,
    ST_M,
    ST_BR,
    ST_TD,
    ST_NUM,
    ST_DIV,
    ST_SUM
  } pid_state_t;

  typedef struct packed {
    logic signed [31:0] setpoint;
    logic signed [31:0] measurement;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               clamped;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
    if (v > 48'sh0000_7FFF_FFFF) begin
      return INT32_MAX;
    end else if (v < 48'shFFFF_8000_0000) begin
      return INT32_MIN;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    if (v > 34'sh0_7FFF_FFFF) begin
      return INT32_MAX;
    end else if (v < 34'sh3_8000_0000) begin
      return INT32_MIN;
    end
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

FILE: sv/pid_mul.sv
// Shared signed 32 x 32 multiplier with a registered 64-bit product.
// Depends on pid_pkg for the operand and product widths.
`timescale 1ns / 1ps
`default_nettype none
module pid_mul (
  input  wire logic                              clk,
  input  wire logic signed [pid_pkg::DATA_W-1:0] mul_a,
  input  wire logic signed [pid_pkg::DATA_W-1:0] mul_b,
  output logic signed [pid_pkg::PROD_W-1:0]      prod_r
);
  import pid_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule
`default_nettype wire

FILE: sv/pid_div.sv
// Restoring divider for unsigned magnitudes, one quotient bit per cycle.
// Depends on pid_pkg for widths and the request struct.
`timescale 1ns / 1ps
`default_nettype none
module pid_div (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire pid_pkg::div_req_t    req,
  output logic                      busy,
  output logic [pid_pkg::NUM_W-1:0] quotient
);
  import pid_pkg::*;

  logic [NUM_W-1:0]     quo_r, quo_nxt;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W:0]       shifted;
  logic [DEN_W:0]       trial;
  logic                 fits;

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;
  assign shifted  = {rem_r, quo_r[NUM_W-1]};
  assign trial    = shifted - {1'b0, den_r};
  assign fits     = (shifted >= {1'b0, den_r});

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    if (req.start) begin
      quo_nxt = req.dividend;
      rem_nxt = '0;
      den_nxt = req.divisor;
      cnt_nxt = DIV_CNT_W'(NUM_W);
    end else if (busy) begin
      rem_nxt = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

endmodule
`default_nettype wire

FILE: sv/pid_controller_antiwindup_core.sv
// Top level of the Q16.16 PID controller: configuration registers, sequencer and state.
// Depends on pid_pkg, pid_mul and pid_div.
//
// Usage: an input transfer on in_valid/in_ready carries a setpoint and a
// measurement; each one yields exactly one output transfer on out_valid/out_ready
// carrying the clamped drive and the clamped flag. Configuration registers must
// be written through cfg_we, cfg_index and cfg_wdata only while the block is
// idle; the block itself does not enforce this, the user must keep to it.
// A sample passes through products and sums on the shared multiplier, then
// the bit-serial divider for the filtered derivative, then the clamp. When
// deriv_time plus deriv_filter is zero the divider is skipped. in_ready is
// high only while the sequencer is idle, so a new sample may enter while the
// last result waits in the output register; in_ready rises together with
// out_valid, and no new sample is taken before the last one is finished.
// If the receiver stalls, the sequencer holds the finished sample until the
// output register is free. Synchronous reset clears the controller state,
// loads the default configuration and empties the output.
`timescale 1ns / 1ps
`default_nettype none
module pid_controller_antiwindup_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire pid_pkg::in_item_t                    in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output pid_pkg::out_item_t                        out_data,
  input  wire logic                                 cfg_we,
  input  wire logic [pid_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [pid_pkg::DATA_W-1:0]           cfg_wdata
);
  import pid_pkg::*;

  logic signed [31:0] k_r, ti_r, td_r, n_r, b_r, min_r, max_r;

  pid_state_t state_r, state_nxt;

  logic signed [31:0] w_r, w_nxt, y_r, y_nxt;
  logic signed [32:0] den_r, den_nxt;
  logic signed [31:0] e_r, e_nxt, dy_r, dy_nxt, kti_r, kti_nxt, p_r, p_nxt;
  logic signed [31:0] i_r, i_nxt, kn_r, kn_nxt, br_r, br_nxt, d_r, d_nxt;

  logic signed [31:0] integ_r, integ_nxt, deriv_r, deriv_nxt;
  logic signed [31:0] ylast_r, ylast_nxt, ulast_r, ulast_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic signed [31:0]     mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [31:0]     qv;

  div_req_t          div_req;
  logic              div_busy;
  logic [NUM_W-1:0]  div_quo;

  logic signed [31:0] u_sum, u_hi;
  logic               lim_hi;

  pid_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  pid_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign qv        = sat48(prod_r[PROD_W-1:16]);

  assign u_sum  = sat34(34'(p_r) + 34'(i_r) + 34'(d_r));
  assign lim_hi = (u_sum >= max_r);
  assign u_hi   = lim_hi ? max_r : u_sum;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_BW: begin
        mul_a = b_r;
        mul_b = w_r;
      end
      ST_E: begin
        mul_a = k_r;
        mul_b = ti_r;
      end
      ST_KTI: begin
        mul_a = k_r;
        mul_b = e_r;
      end
      ST_P: begin
        mul_a = kti_r;
        mul_b = e_r;
      end
      ST_IE: begin
        mul_a = k_r;
        mul_b = n_r;
      end
      ST_M: begin
        mul_a = kn_r;
        mul_b = dy_r;
      end
      ST_TD: begin
        mul_a = td_r;
        mul_b = br_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    w_nxt         = w_r;
    y_nxt         = y_r;
    den_nxt       = den_r;
    e_nxt         = e_r;
    dy_nxt        = dy_r;
    kti_nxt       = kti_r;
    p_nxt         = p_r;
    i_nxt         = i_r;
    kn_nxt        = kn_r;
    br_nxt        = br_r;
    d_nxt         = d_r;
    integ_nxt     = integ_r;
    deriv_nxt     = deriv_r;
    ylast_nxt     = ylast_r;
    ulast_nxt     = ulast_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    div_req.start    = 1'b0;
    div_req.dividend = prod_r[PROD_W-1] ? NUM_W'(-prod_r) : prod_r[NUM_W-1:0];
    div_req.divisor  = den_r[DEN_W-1] ? DEN_W'(-den_r) : DEN_W'(den_r);

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          w_nxt     = in_data.setpoint;
          y_nxt     = in_data.measurement;
          den_nxt   = 33'(td_r) + 33'(n_r);
          state_nxt = ST_BW;
        end
      end
      ST_BW: begin
        state_nxt = ST_E;
      end
      ST_E: begin
        e_nxt     = sat34(34'(qv) - 34'(y_r));
        dy_nxt    = sat34(34'(y_r) - 34'(ylast_r));
        state_nxt = ST_KTI;
      end
      ST_KTI: begin
        kti_nxt   = qv;
        state_nxt = ST_P;
      end
      ST_P: begin
        p_nxt     = qv;
        state_nxt = ST_IE;
      end
      ST_IE: begin
        if (ulast_r <= min_r || ulast_r >= max_r) begin
          i_nxt = '0;
        end else begin
          i_nxt = sat34(34'(integ_r) + 34'(qv));
        end
        state_nxt = ST_KN;
      end
      ST_KN: begin
        kn_nxt    = qv;
        state_nxt = ST_M;
      end
      ST_M: begin
        state_nxt = ST_BR;
      end
      ST_BR: begin
        br_nxt = sat34(34'(deriv_r) - 34'(qv));
        if (den_r == '0) begin
          d_nxt     = '0;
          state_nxt = ST_SUM;
        end else begin
          state_nxt = ST_TD;
        end
      end
      ST_TD: begin
        state_nxt = ST_NUM;
      end
      ST_NUM: begin
        div_req.start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (!div_busy) begin
          if (br_r[31] ^ td_r[31] ^ den_r[32]) begin
            d_nxt = (div_quo > NUM_W'(64'd2147483648)) ? INT32_MIN : 32'(-div_quo);
          end else begin
            d_nxt = (div_quo > NUM_W'(64'd2147483647)) ? INT32_MAX : div_quo[31:0];
          end
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.drive   = (u_hi < min_r) ? min_r : u_hi;
          out_data_nxt.clamped = lim_hi || (u_hi < min_r);
          ulast_nxt            = (u_hi < min_r) ? min_r : u_hi;
          integ_nxt            = i_r;
          deriv_nxt            = d_r;
          ylast_nxt            = y_r;
          state_nxt            = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      deriv_r     <= '0;
      ylast_r     <= '0;
      ulast_r     <= '0;
      k_r         <= RST_PROP_GAIN;
      ti_r        <= RST_INTEGRAL_COEF;
      td_r        <= RST_DERIV_TIME;
      n_r         <= RST_DERIV_FILTER;
      b_r         <= RST_SETPOINT_WEIGHT;
      min_r       <= RST_OUT_MIN;
      max_r       <= RST_OUT_MAX;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      integ_r     <= integ_nxt;
      deriv_r     <= deriv_nxt;
      ylast_r     <= ylast_nxt;
      ulast_r     <= ulast_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_PROP_GAIN:       k_r   <= cfg_wdata;
          REG_INTEGRAL_COEF:   ti_r  <= cfg_wdata;
          REG_DERIV_TIME:      td_r  <= cfg_wdata;
          REG_DERIV_FILTER:    n_r   <= cfg_wdata;
          REG_SETPOINT_WEIGHT: b_r   <= cfg_wdata;
          REG_OUT_MIN:         min_r <= cfg_wdata;
          REG_OUT_MAX:         max_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
    w_r        <= w_nxt;
    y_r        <= y_nxt;
    den_r      <= den_nxt;
    e_r        <= e_nxt;
    dy_r       <= dy_nxt;
    kti_r      <= kti_nxt;
    p_r        <= p_nxt;
    i_r        <= i_nxt;
    kn_r       <= kn_nxt;
    br_r       <= br_nxt;
    d_r        <= d_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire
